>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the stereo DC blocker and FIR block.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/sdcfir_pkg.sv
// Shared types and constants of the stereo DC blocker and FIR block.
// Used by the tap cell, the DC blocker and the top level.
package sdcfir_pkg;

  localparam int POLE_WIDTH = 23;
  localparam int POLE_FRAC  = 23;

  localparam logic OP_FRAME     = 1'b0;
  localparam logic OP_COEF_LOAD = 1'b1;
  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_DC_POLE  = 1'b1;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/sdcfir_cell.sv
// One tap cell of the FIR ring: a coefficient and the left and right history words.
// Depends on sdcfir_pkg for the control struct.
module sdcfir_cell
  import sdcfir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cell_ctrl_t                     ctrl,
  input  logic                           load,
  input  logic signed [COEF_WIDTH-1:0]   load_coef,
  input  logic signed [COEF_WIDTH-1:0]   rot_coef,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_left,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_right,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_left,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_right,
  output logic signed [COEF_WIDTH-1:0]   coef,
  output logic signed [SAMPLE_WIDTH-1:0] hist_left,
  output logic signed [SAMPLE_WIDTH-1:0] hist_right
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef       <= '0;
      hist_left  <= '0;
      hist_right <= '0;
    end else begin
      priority if (load) begin
        coef <= load_coef;
      end else if (ctrl.rotate) begin
        coef       <= rot_coef;
        hist_left  <= rot_left;
        hist_right <= rot_right;
      end else if (ctrl.insert) begin
        hist_left  <= shift_left;
        hist_right <= shift_right;
      end else begin
        coef       <= coef;
        hist_left  <= hist_left;
        hist_right <= hist_right;
      end
    end
  end

endmodule

>>> hw/rtl/sdcfir_dc.sv
// One-pole DC blocker for one channel, with its previous input and output words.
// Depends on sdcfir_pkg for the pole format.
module sdcfir_dc
  import sdcfir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mul_en,
  input  logic                           commit,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic [POLE_WIDTH-1:0]          pole,
  output logic signed [SAMPLE_WIDTH-1:0] y
);

  localparam int FBW = POLE_WIDTH + 1 + SAMPLE_WIDTH;
  localparam int SUMW = SAMPLE_WIDTH + 3;
  localparam logic signed [SUMW-1:0] Y_MAX = (SUMW'(1) << (SAMPLE_WIDTH - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] Y_MIN = ~Y_MAX;

  logic signed [SAMPLE_WIDTH-1:0] prev_in;
  logic signed [SAMPLE_WIDTH-1:0] prev_out;
  logic signed [FBW-1:0]          fb;
  logic signed [FBW:0]            fb_sum;
  logic signed [FBW:0]            fb_sh;
  logic signed [SAMPLE_WIDTH:0]   fb_n;
  logic signed [SUMW-1:0]         sum;

  always_comb begin
    fb_sum = (FBW + 1)'(fb) + ((FBW + 1)'(1) << (POLE_FRAC - 1));
    fb_sh  = fb_sum >>> POLE_FRAC;
    fb_n   = fb_sh[SAMPLE_WIDTH:0];
    sum    = SUMW'(x) - SUMW'(prev_in) + SUMW'(fb_n);
    if (sum > Y_MAX) begin
      y = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (sum < Y_MIN) begin
      y = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y = sum[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_in  <= '0;
      prev_out <= '0;
    end else if (commit) begin
      prev_in  <= x;
      prev_out <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      fb <= FBW'($signed({1'b0, pole})) * FBW'(prev_out);
    end
  end

endmodule

>>> hw/rtl/stereo_dc_block_fir_output_core.sv
// Stereo DC blocker followed by a FIR filter, as a rotating ring of tap cells.
// Depends on sdcfir_pkg, sdcfir_cell, sdcfir_dc and assert_macros.svh.
//
// Input channel (in_valid/in_ready): one word per frame or coefficient load.
//   opcode 0 is a stereo frame, opcode 1 writes coef_value into tap coef_index;
//   an index at or beyond TAPS is dropped. A load gives no word and leaves the block idle.
// Output channel (out_valid/out_ready): one word per frame, held in a register.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 enable, 1 DC pole.
//   Write it only while the block is idle.
// The processing time of a filtered frame is set by the single multiply-accumulate
//   per channel that the cell ring rotates past once per tap. A frame with
//   filtering disabled changes no filter state.
// in_ready is high only when no frame is in progress; a finished word waits in
//   the output register while the next input word is taken. A stalled receiver
//   holds the block before the output register is overwritten.
// Reset clears all taps, history words, DC blocker state and the tap counter,
//   sets enable to 1 and the DC pole to its default; it is synchronous.
`include "assert_macros.svh"

module stereo_dc_block_fir_output_core
  import sdcfir_pkg::*;
#(
  parameter int TAPS         = 31,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
  input  logic [4:0]                     coef_index,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [POLE_WIDTH-1:0]          cfg_data
);

  localparam logic [POLE_WIDTH-1:0] DC_POLE_RESET = POLE_WIDTH'(8365557);

  localparam int ACC_WIDTH = 64;
  localparam int PW        = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int CNT_W     = $clog2(TAPS + 1);
  localparam int IW        = (CNT_W > 5) ? CNT_W : 5;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [ACC_WIDTH-1:0] ROUND   = ACC_WIDTH'(1) << (COEF_WIDTH - 2);
  localparam logic signed [ACC_WIDTH-1:0] OUT_MAX =
    (ACC_WIDTH'(1) << (SAMPLE_WIDTH - 1)) - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DC_MUL,
    S_DC_SUM,
    S_MAC,
    S_FINISH,
    S_EMIT
  } state_t;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [ACC_WIDTH-1:0] b
  );
    logic [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACC_WIDTH-1:0] v
  );
    logic signed [ACC_WIDTH-1:0] sh;
    sh = v >>> (COEF_WIDTH - 1);
    if (sh > OUT_MAX) begin
      return OUT_MAX[SAMPLE_WIDTH-1:0];
    end
    if (sh < OUT_MIN) begin
      return OUT_MIN[SAMPLE_WIDTH-1:0];
    end
    return sh[SAMPLE_WIDTH-1:0];
  endfunction

  state_t                         state;
  logic [CNT_W-1:0]               count;
  logic                           enable_filter;
  logic [POLE_WIDTH-1:0]          dc_pole_coef;
  logic signed [SAMPLE_WIDTH-1:0] x_left;
  logic signed [SAMPLE_WIDTH-1:0] x_right;
  logic signed [SAMPLE_WIDTH-1:0] y_left;
  logic signed [SAMPLE_WIDTH-1:0] y_right;
  logic signed [PW-1:0]           prod_left;
  logic signed [PW-1:0]           prod_right;
  logic signed [ACC_WIDTH-1:0]    acc_left;
  logic signed [ACC_WIDTH-1:0]    acc_right;
  logic signed [SAMPLE_WIDTH-1:0] res_left;
  logic signed [SAMPLE_WIDTH-1:0] res_right;

  logic                           in_accept;
  logic                           load_go;
  logic [IW-1:0]                  idx_ext;
  cell_ctrl_t                     ctrl;
  logic [TAPS-1:0]                load_sel;

  logic signed [COEF_WIDTH-1:0]   coef_w  [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hl_w    [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hr_w    [TAPS];

  assign in_ready    = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && in_ready;
  assign idx_ext     = IW'(coef_index);
  assign load_go     = in_accept && (opcode == OP_COEF_LOAD) && (idx_ext < IW'(TAPS));
  assign ctrl.insert = (state == S_DC_SUM);
  assign ctrl.rotate = (state == S_MAC) && (count < CNT_W'(TAPS));

  sdcfir_dc #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dc_left (
    .clk    (clk),
    .rst    (rst),
    .mul_en (state == S_DC_MUL),
    .commit (state == S_DC_SUM),
    .x      (x_left),
    .pole   (dc_pole_coef),
    .y      (y_left)
  );

  sdcfir_dc #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dc_right (
    .clk    (clk),
    .rst    (rst),
    .mul_en (state == S_DC_MUL),
    .commit (state == S_DC_SUM),
    .x      (x_right),
    .pole   (dc_pole_coef),
    .y      (y_right)
  );

  for (genvar t = 0; t < TAPS; t++) begin : g_cell
    localparam int NEXT = (t + 1) % TAPS;

    assign load_sel[t] = load_go && (idx_ext == IW'(t));

    if (t == 0) begin : g_head
      sdcfir_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .load        (load_sel[t]),
        .load_coef   (coef_value),
        .rot_coef    (coef_w[NEXT]),
        .rot_left    (hl_w[NEXT]),
        .rot_right   (hr_w[NEXT]),
        .shift_left  (y_left),
        .shift_right (y_right),
        .coef        (coef_w[t]),
        .hist_left   (hl_w[t]),
        .hist_right  (hr_w[t])
      );
    end else begin : g_body
      sdcfir_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .load        (load_sel[t]),
        .load_coef   (coef_value),
        .rot_coef    (coef_w[NEXT]),
        .rot_left    (hl_w[NEXT]),
        .rot_right   (hr_w[NEXT]),
        .shift_left  (hl_w[t-1]),
        .shift_right (hr_w[t-1]),
        .coef        (coef_w[t]),
        .hist_left   (hl_w[t]),
        .hist_right  (hr_w[t])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      enable_filter <= 1'b1;
      dc_pole_coef  <= DC_POLE_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ENABLE:  enable_filter <= cfg_data[0];
          REG_DC_POLE: dc_pole_coef  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept && (opcode == OP_FRAME)) begin
            x_left  <= left_sample;
            x_right <= right_sample;
            if (enable_filter) begin
              state <= S_DC_MUL;
            end else begin
              res_left  <= left_sample;
              res_right <= right_sample;
              state     <= S_EMIT;
            end
          end
        end
        S_DC_MUL: begin
          state <= S_DC_SUM;
        end
        S_DC_SUM: begin
          acc_left  <= '0;
          acc_right <= '0;
          count     <= '0;
          state     <= S_MAC;
        end
        S_MAC: begin
          if (count < CNT_W'(TAPS)) begin
            prod_left  <= PW'(coef_w[0]) * PW'(hl_w[0]);
            prod_right <= PW'(coef_w[0]) * PW'(hr_w[0]);
          end
          if (count != '0) begin
            acc_left  <= sat_add(acc_left, ACC_WIDTH'(prod_left));
            acc_right <= sat_add(acc_right, ACC_WIDTH'(prod_right));
          end
          if (count == CNT_W'(TAPS)) begin
            state <= S_FINISH;
          end
          count <= count + CNT_W'(1);
        end
        S_FINISH: begin
          res_left  <= sat_sample(sat_add(acc_left, ROUND));
          res_right <= sat_sample(sat_add(acc_right, ROUND));
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            left_out  <= res_left;
            right_out <= res_right;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_SAME_CYCLE(a_count_bound, clk, rst, state == S_MAC, count <= CNT_W'(TAPS), "tap count overran")
  `ASSERT_NEXT_CYCLE(a_mac_start, clk, rst, state == S_DC_SUM, (state == S_MAC) && (count == '0), "accumulation did not start")
  `ASSERT_NEXT_CYCLE(a_load_idle, clk, rst, in_accept && (opcode == OP_COEF_LOAD), state == S_IDLE, "coefficient load left idle")
  `ASSERT_NEXT_CYCLE(a_emit_word, clk, rst, (state == S_EMIT) && (!out_valid || out_ready), out_valid && (state == S_IDLE), "word not presented")

endmodule
